[sv/ttft_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttft_pkg
// Shared types and codes of the character-table source tokenizer.
// ----------------------------------------------------------------------------
package ttft_pkg;

  typedef enum logic [3:0] {
    TK_NAMECHAR    = 4'd0,
    TK_NAMEDONE    = 4'd1,
    TK_ENTRYSTART  = 4'd2,
    TK_KEYBYTE     = 4'd3,
    TK_TEXTCHAR    = 4'd4,
    TK_LABELCHAR   = 4'd5,
    TK_BREAKMARK   = 4'd6,
    TK_PARAMCHAR   = 4'd7,
    TK_PARAMFORMAT = 4'd8,
    TK_ENTRYDONE   = 4'd9,
    TK_SOURCEOK    = 4'd10,
    TK_ERROR       = 4'd11
  } tok_kind_e;

  typedef enum logic [7:0] {
    ER_CHAR   = 8'd0,
    ER_EOL    = 8'd1,
    ER_EOF    = 8'd2,
    ER_HEX    = 8'd3,
    ER_PNAME  = 8'd4,
    ER_FORMAT = 8'd5
  } err_e;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_mark;
  } in_item_t;

  typedef struct packed {
    logic [3:0] token_kind;
    logic [7:0] token_value;
    logic       last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [3:0] kind;
    logic [7:0] value;
  } token_t;

  // One or two tokens caused by a single source word
  typedef struct packed {
    logic   two;
    token_t tok0;
    token_t tok1;
  } tok_pair_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

[sv/text_table_file_tokenizer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_table_file_tokenizer
// Character-table source tokenizer, one source byte per word in.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_ready_o / in_data_i): one source byte, or
// the end-of-source mark, per word. Output channel (out_valid_o /
// out_ready_i / out_data_o): typed tokens; last_of_run flags the final token
// caused by one input word. A word gives zero, one or two tokens.
// An accepted word's tokens pass through the token queue and then the output
// register before they are valid on the output.
// Throughput: one input word per cycle while the queue is not full; the
// output side sends one token per cycle while the receiver takes them, so a
// word that closes an entry and starts the next sends two tokens.
// The parser classifies each word combinationally and pushes its tokens
// into a four-entry queue; the sender drains that queue into an output
// register. When the receiver stalls, the output holds, the queue fills and
// in_ready_o falls once it is full; nothing is dropped.
// After an error token or the source-ok token the parser stops and takes
// further words without producing anything until reset. Reset (rst_ni, async,
// active low) returns the parser to the source start and empties the queue.
// ----------------------------------------------------------------------------
module text_table_file_tokenizer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ttft_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ttft_pkg::out_item_t out_data_o
);

  logic                push;
  logic                pop;
  ttft_pkg::tok_pair_t push_pair;
  ttft_pkg::tok_pair_t head_pair;
  ttft_pkg::q_status_t q_status;

  ttft_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_status_i (q_status),
    .push_o     (push),
    .pair_o     (push_pair)
  );

  ttft_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .pair_i   (push_pair),
    .pop_i    (pop),
    .pair_o   (head_pair),
    .status_o (q_status)
  );

  ttft_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pair_i      (head_pair),
    .q_status_i  (q_status),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

[sv/ttft_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttft_front
// Grammar state machine: takes one source word per cycle while the queue is
// not full and classifies it into zero, one or two tokens for the token queue.
// ----------------------------------------------------------------------------
module ttft_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ttft_pkg::in_item_t  in_data_i,
  input  ttft_pkg::q_status_t q_status_i,
  output logic                push_o,
  output ttft_pkg::tok_pair_t pair_o
);

  typedef enum logic [3:0] {
    PH_START, PH_NAME, PH_BETWEEN, PH_KEY_HIGH, PH_KEY_LOW, PH_TEXT,
    PH_LABEL_OPEN, PH_LABEL, PH_ESCAPES, PH_ESC_N, PH_PARAM_FIRST,
    PH_PARAM_NAME, PH_PARAM_PCT, PH_PARAM_FMT, PH_PARAM_AFTER, PH_HALT
  } phase_e;

  typedef struct packed {
    logic         has;
    ttft_pkg::token_t tok;
    phase_e       phase;
    logic         kind_we;
    logic [1:0]   kind;
    logic         nib_we;
    logic [3:0]   nib;
  } disp_t;

  localparam logic [7:0] ChAt     = 8'h40;
  localparam logic [7:0] ChBang   = 8'h21;
  localparam logic [7:0] ChDollar = 8'h24;
  localparam logic [7:0] ChSlash  = 8'h2f;
  localparam logic [7:0] ChEq     = 8'h3d;
  localparam logic [7:0] ChLBrk   = 8'h5b;
  localparam logic [7:0] ChRBrk   = 8'h5d;
  localparam logic [7:0] ChPct    = 8'h25;
  localparam logic [7:0] ChD      = 8'h44;
  localparam logic [7:0] ChX      = 8'h58;
  localparam logic [7:0] ChB      = 8'h42;
  localparam logic [7:0] ChComma  = 8'h2c;
  localparam logic [7:0] ChBslash = 8'h5c;
  localparam logic [7:0] ChN      = 8'h6e;
  localparam logic [7:0] ChLf     = 8'h0a;
  localparam logic [7:0] ChCr     = 8'h0d;

  localparam logic [1:0] KindText    = 2'd0;
  localparam logic [1:0] KindSwitch  = 2'd1;
  localparam logic [1:0] KindEnd     = 2'd2;
  localparam logic [1:0] KindControl = 2'd3;

  phase_e     phase_q, phase_d;
  logic [1:0] kind_q, kind_d;
  logic [3:0] nib_q, nib_d;
  logic       named_q, named_d;

  function automatic logic [4:0] hex_of(logic [7:0] c);
    // {valid, value}
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
    return r;
  endfunction

  function automatic logic is_alnum(logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h7a) ||
           (c >= 8'h41 && c <= 8'h5a);
  endfunction

  function automatic ttft_pkg::token_t mk(ttft_pkg::tok_kind_e k, logic [7:0] v);
    ttft_pkg::token_t t;
    t.kind  = k;
    t.value = v;
    return t;
  endfunction

  // Entry boundary: start an entry, skip a line break, finish the source, or flag a bad character
  function automatic disp_t dispatch(logic [7:0] c, logic eos, logic skip);
    disp_t      d;
    logic [4:0] h;
    logic [1:0] k;
    d       = '0;
    d.phase = PH_HALT;
    h       = hex_of(c);
    k       = (c == ChBang) ? KindSwitch : (c == ChSlash) ? KindEnd : KindControl;
    if (eos) begin
      d.has = 1'b1;
      d.tok = mk(ttft_pkg::TK_SOURCEOK, 8'd0);
    end else if (skip && (c == ChLf || c == ChCr)) begin
      d.phase = PH_BETWEEN;
    end else if (c == ChBang || c == ChSlash || c == ChDollar) begin
      d.has     = 1'b1;
      d.tok     = mk(ttft_pkg::TK_ENTRYSTART, {6'd0, k});
      d.phase   = PH_KEY_HIGH;
      d.kind_we = 1'b1;
      d.kind    = k;
    end else if (h[4]) begin
      d.has     = 1'b1;
      d.tok     = mk(ttft_pkg::TK_ENTRYSTART, {6'd0, KindText});
      d.phase   = PH_KEY_LOW;
      d.kind_we = 1'b1;
      d.kind    = KindText;
      d.nib_we  = 1'b1;
      d.nib     = h[3:0];
    end else begin
      d.has = 1'b1;
      d.tok = mk(ttft_pkg::TK_ERROR, ttft_pkg::ER_CHAR);
    end
    return d;
  endfunction

  logic       accept;
  logic       eos;
  logic [7:0] c;
  logic       nul;
  logic       brk;
  logic [4:0] hx;
  logic [1:0] n_tok;
  disp_t      dsp;

  assign in_ready_o = !q_status_i.full;
  assign accept     = in_valid_i && in_ready_o;
  assign eos        = in_data_i.end_mark;
  assign c          = eos ? 8'd0 : in_data_i.char_code;
  assign nul        = (c == 8'd0);
  assign brk        = (c == ChLf) || (c == ChCr);
  assign hx         = hex_of(c);

  always_comb begin
    phase_d     = phase_q;
    kind_d      = kind_q;
    nib_d       = nib_q;
    named_d     = named_q;
    n_tok       = 2'd0;
    pair_o      = '0;
    dsp         = dispatch(c, eos, phase_q != PH_START);
    unique case (phase_q)
      PH_START, PH_BETWEEN: begin
        if (phase_q == PH_START && !eos && c == ChAt) begin
          phase_d = PH_NAME;
        end else begin
          n_tok       = {1'b0, dsp.has};
          pair_o.tok0 = dsp.tok;
          phase_d     = dsp.phase;
          if (dsp.kind_we) kind_d = dsp.kind;
          if (dsp.nib_we) nib_d = dsp.nib;
        end
      end
      PH_NAME: begin
        n_tok = 2'd1;
        if (brk) begin
          pair_o.tok0 = mk(ttft_pkg::TK_NAMEDONE, {7'd0, named_q});
          phase_d     = PH_BETWEEN;
        end else if (nul) begin
          pair_o.tok0 = mk(ttft_pkg::TK_ERROR, ttft_pkg::ER_EOF);
          phase_d     = PH_HALT;
        end else if (c == ChComma) begin
          pair_o.tok0 = mk(ttft_pkg::TK_ERROR, ttft_pkg::ER_CHAR);
          phase_d     = PH_HALT;
        end else begin
          named_d     = 1'b1;
          pair_o.tok0 = mk(ttft_pkg::TK_NAMECHAR, c);
        end
      end
      PH_KEY_HIGH: begin
        if (!eos && hx[4]) begin
          nib_d   = hx[3:0];
          phase_d = PH_KEY_LOW;
        end else if (!eos && c == ChEq) begin
          phase_d = (kind_q == KindText) ? PH_TEXT : PH_LABEL_OPEN;
        end else begin
          n_tok       = 2'd1;
          pair_o.tok0 = mk(ttft_pkg::TK_ERROR, ttft_pkg::ER_CHAR);
          phase_d     = PH_HALT;
        end
      end
      PH_KEY_LOW: begin
        n_tok = 2'd1;
        if (!eos && hx[4]) begin
          pair_o.tok0 = mk(ttft_pkg::TK_KEYBYTE, {nib_q, hx[3:0]});
          phase_d     = PH_KEY_HIGH;
        end else begin
          pair_o.tok0 = mk(ttft_pkg::TK_ERROR, ttft_pkg::ER_HEX);
          phase_d     = PH_HALT;
        end
      end
      PH_TEXT: begin
        n_tok = 2'd1;
        if (brk) begin
          pair_o.tok0 = mk(ttft_pkg::TK_ENTRYDONE, 8'd0);
          phase_d     = PH_BETWEEN;
        end else if (nul) begin
          pair_o.tok0 = mk(ttft_pkg::TK_ERROR, ttft_pkg::ER_EOF);
          phase_d     = PH_HALT;
        end else begin
          pair_o.tok0 = mk(ttft_pkg::TK_TEXTCHAR, c);
        end
      end
      PH_LABEL_OPEN: begin
        if (!eos && c == ChLBrk) begin
          phase_d = PH_LABEL;
        end else begin
          n_tok       = 2'd1;
          pair_o.tok0 = mk(ttft_pkg::TK_ERROR, ttft_pkg::ER_CHAR);
          phase_d     = PH_HALT;
        end
      end
      PH_LABEL: begin
        if (!eos && c == ChRBrk) begin
          if (kind_q == KindSwitch) begin
            n_tok       = 2'd1;
            pair_o.tok0 = mk(ttft_pkg::TK_ENTRYDONE, 8'd0);
            phase_d     = PH_BETWEEN;
          end else begin
            phase_d = PH_ESCAPES;
          end
        end else if (nul) begin
          n_tok       = 2'd1;
          pair_o.tok0 = mk(ttft_pkg::TK_ERROR, ttft_pkg::ER_EOF);
          phase_d     = PH_HALT;
        end else if (brk) begin
          n_tok       = 2'd1;
          pair_o.tok0 = mk(ttft_pkg::TK_ERROR, ttft_pkg::ER_EOL);
          phase_d     = PH_HALT;
        end else begin
          n_tok       = 2'd1;
          pair_o.tok0 = mk(ttft_pkg::TK_LABELCHAR, c);
        end
      end
      PH_ESCAPES, PH_PARAM_AFTER: begin
        if (phase_q == PH_ESCAPES && !eos && c == ChBslash) begin
          phase_d = PH_ESC_N;
        end else if (!eos && c == ChComma &&
                     (phase_q == PH_PARAM_AFTER || kind_q == KindControl)) begin
          phase_d = PH_PARAM_FIRST;
        end else begin
          // close the entry, then treat this word as an entry boundary
          n_tok       = dsp.has ? 2'd2 : 2'd1;
          pair_o.tok0 = mk(ttft_pkg::TK_ENTRYDONE, 8'd0);
          pair_o.tok1 = dsp.tok;
          phase_d     = dsp.phase;
          if (dsp.kind_we) kind_d = dsp.kind;
          if (dsp.nib_we) nib_d = dsp.nib;
        end
      end
      PH_ESC_N: begin
        n_tok = 2'd1;
        if (!eos && c == ChN) begin
          pair_o.tok0 = mk(ttft_pkg::TK_BREAKMARK, 8'd0);
          phase_d     = PH_ESCAPES;
        end else begin
          pair_o.tok0 = mk(ttft_pkg::TK_ERROR, ttft_pkg::ER_CHAR);
          phase_d     = PH_HALT;
        end
      end
      PH_PARAM_FIRST: begin
        n_tok = 2'd1;
        if (!eos && is_alnum(c)) begin
          pair_o.tok0 = mk(ttft_pkg::TK_PARAMCHAR, c);
          phase_d     = PH_PARAM_NAME;
        end else begin
          pair_o.tok0 = mk(ttft_pkg::TK_ERROR, ttft_pkg::ER_PNAME);
          phase_d     = PH_HALT;
        end
      end
      PH_PARAM_NAME: begin
        if (!eos && is_alnum(c)) begin
          n_tok       = 2'd1;
          pair_o.tok0 = mk(ttft_pkg::TK_PARAMCHAR, c);
        end else if (!eos && c == ChEq) begin
          phase_d = PH_PARAM_PCT;
        end else begin
          n_tok       = 2'd1;
          pair_o.tok0 = mk(ttft_pkg::TK_ERROR, ttft_pkg::ER_CHAR);
          phase_d     = PH_HALT;
        end
      end
      PH_PARAM_PCT: begin
        if (!eos && c == ChPct) begin
          phase_d = PH_PARAM_FMT;
        end else begin
          n_tok       = 2'd1;
          pair_o.tok0 = mk(ttft_pkg::TK_ERROR, ttft_pkg::ER_CHAR);
          phase_d     = PH_HALT;
        end
      end
      PH_PARAM_FMT: begin
        n_tok = 2'd1;
        if (!eos && (c == ChD || c == ChX || c == ChB)) begin
          pair_o.tok0 = mk(ttft_pkg::TK_PARAMFORMAT,
                           (c == ChD) ? 8'd0 : (c == ChX) ? 8'd1 : 8'd2);
          phase_d     = PH_PARAM_AFTER;
        end else begin
          pair_o.tok0 = mk(ttft_pkg::TK_ERROR, ttft_pkg::ER_FORMAT);
          phase_d     = PH_HALT;
        end
      end
      PH_HALT: begin
        phase_d = PH_HALT;
      end
    endcase
    pair_o.two = (n_tok == 2'd2);
  end

  assign push_o = accept && (n_tok != 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_START;
      kind_q  <= 2'd0;
      nib_q   <= 4'd0;
      named_q <= 1'b0;
    end else if (accept) begin
      phase_q <= phase_d;
      kind_q  <= kind_d;
      nib_q   <= nib_d;
      named_q <= named_d;
    end
  end

  // Stopped parser never pushes a token
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_HALT |-> !push_o)
    else $error("token pushed after stop");

  // Error or source end always halts the parser
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o && (pair_o.tok0.kind == ttft_pkg::TK_ERROR ||
               pair_o.tok0.kind == ttft_pkg::TK_SOURCEOK) |=> phase_q == PH_HALT)
    else $error("parser did not stop");

endmodule

[sv/ttft_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttft_queue
// Short queue of token pairs between the parser and the token sender.
// ----------------------------------------------------------------------------
module ttft_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  ttft_pkg::tok_pair_t pair_i,
  input  logic                pop_i,
  output ttft_pkg::tok_pair_t pair_o,
  output ttft_pkg::q_status_t status_o
);

  ttft_pkg::tok_pair_t                       mem_q [ttft_pkg::QDepth];
  logic [ttft_pkg::QPtrW-1:0]                wptr_q, rptr_q;
  logic [ttft_pkg::QCntW-1:0]                cnt_q;

  assign status_o.full  = (cnt_q == ttft_pkg::QCntW'(ttft_pkg::QDepth));
  assign status_o.empty = (cnt_q == '0);
  assign pair_o         = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= pair_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) wptr_q <= wptr_q + ttft_pkg::QPtrW'(1);
      if (pop_i) rptr_q <= rptr_q + ttft_pkg::QPtrW'(1);
      if (push_i && !pop_i) cnt_q <= cnt_q + ttft_pkg::QCntW'(1);
      else if (pop_i && !push_i) cnt_q <= cnt_q - ttft_pkg::QCntW'(1);
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_o.full |-> !push_i)
    else $error("push into full queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_o.empty |-> !pop_i)
    else $error("pop from empty queue");

endmodule

[sv/ttft_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttft_back
// Token sender: unpacks each queued pair into one or two output words and
// holds them in an output register until taken.
// ----------------------------------------------------------------------------
module ttft_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ttft_pkg::tok_pair_t  pair_i,
  input  ttft_pkg::q_status_t  q_status_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output ttft_pkg::out_item_t  out_data_o
);

  logic                out_valid_q;
  ttft_pkg::out_item_t out_q;
  logic                pend_q;
  ttft_pkg::token_t    pend_tok_q;
  logic                can_load;

  assign can_load    = !out_valid_q || out_ready_i;
  assign pop_o       = can_load && !pend_q && !q_status_i.empty;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
    end else if (can_load) begin
      if (pend_q) begin
        out_valid_q <= 1'b1;
        pend_q      <= 1'b0;
      end else if (!q_status_i.empty) begin
        out_valid_q <= 1'b1;
        pend_q      <= pair_i.two;
      end else begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (can_load) begin
      if (pend_q) begin
        out_q.token_kind  <= pend_tok_q.kind;
        out_q.token_value <= pend_tok_q.value;
        out_q.last_of_run <= 1'b1;
      end else if (!q_status_i.empty) begin
        out_q.token_kind  <= pair_i.tok0.kind;
        out_q.token_value <= pair_i.tok0.value;
        out_q.last_of_run <= !pair_i.two;
        pend_tok_q        <= pair_i.tok1;
      end
    end
  end

  // Second token of a pair waits only behind the first one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> out_valid_q && !out_q.last_of_run)
    else $error("pending token without its lead word");

endmodule
